// ----- sv/sysex_dump_check_unpack_top_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros for the sysex dump checker
// immediate-consequence and next-cycle property forms on clk and rst_n
// ---------------------------------------------------------------------------
`ifndef SYSEX_DUMP_CHECK_UNPACK_TOP_MACROS_SVH
`define SYSEX_DUMP_CHECK_UNPACK_TOP_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define SDCU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequence holds in the cycle after the antecedent
`define SDCU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sdcu_pkg.sv -----
// ---------------------------------------------------------------------------
// sdcu_pkg
// types, codes and helpers shared by the sysex dump checker modules
// ---------------------------------------------------------------------------
`default_nettype none

package sdcu_pkg;

  // one input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } sdcu_in_t;

  // one result request
  typedef struct packed {
    logic [7:0]  out_value;
    logic [6:0]  repeat_count;
    logic        is_status;
    logic [2:0]  status_code;
    logic [6:0]  slot_byte;
    logic [15:0] decoded_total;
  } sdcu_out_t;

  // configuration registers
  typedef struct packed {
    logic [6:0] product_id;
    logic [6:0] command_code;
    logic       unpack_enable;
  } sdcu_cfg_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        eom;
    logic        hdr_err;
    logic        pos_ge1;
    logic        pos_is9;
    logic        sum_en;
    logic        dec_en;
    logic        n_ge13;
    logic        n_lt10;
    logic [15:0] nm10;
  } sdcu_qent_t;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_HEADER   = 3'd1;
  localparam logic [2:0] ST_HIGH_BIT = 3'd2;
  localparam logic [2:0] ST_CHECKSUM = 3'd3;
  localparam logic [2:0] ST_LENGTH   = 3'd4;
  localparam logic [2:0] ST_BAD_RUN  = 3'd5;
  localparam logic [2:0] ST_OVERFLOW = 3'd6;

  // register indexes
  localparam logic [1:0] REG_PRODUCT_ID    = 2'd0;
  localparam logic [1:0] REG_COMMAND_CODE  = 2'd1;
  localparam logic [1:0] REG_UNPACK_ENABLE = 2'd2;

  // fixed message bytes
  localparam logic [7:0] SOX_BYTE   = 8'hf0;
  localparam logic [7:0] MAN_ID1    = 8'h20;
  localparam logic [7:0] MAN_ID2    = 8'h3c;
  localparam logic [7:0] EOX_BYTE   = 8'hf7;
  localparam logic [6:0] RESET_PRODUCT = 7'd2;
  localparam logic [6:0] RESET_COMMAND = 7'd82;

  // hand-off queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // lowest nonzero code wins
  function automatic logic [2:0] merge_err(input logic [2:0] cur, input logic [2:0] add);
    if (cur == ST_OK || (add != ST_OK && add < cur)) begin
      return add;
    end
    return cur;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sysex_dump_check_unpack_top.sv -----
// ---------------------------------------------------------------------------
// sysex_dump_check_unpack_top
// system-exclusive dump checker with 7-bit unpack and run-length decode
// ---------------------------------------------------------------------------
// usage:
//   bytes of a dump are pushed on in_data while in_full is low; the byte with
//   end_of_message set is the trailer. results come out like a queue: while
//   out_empty is low, out_data holds the oldest result, taken with out_pop.
//   decoded requests are tentative; the status request after each trailer
//   gives the message verdict, slot byte and decoded total.
// flow:
//   one byte per cycle while in_full is low. results are registered on out_data
//   from the queue head of the completing byte; decoded values trail
//   their raw byte by four positions through the trailer delay line.
// stalls:
//   a four-entry queue sits between the classifying front end and the decode
//   back end; while out_data waits, the back end still runs bytes that make
//   no result, and in_full rises only once that queue has filled.
// reset:
//   rst_n low clears the queue, the message state and the result valid flag,
//   and loads the registers with their defaults. the user must write registers
//   over the APB-style port only while no message is in flight; unenforced.
// ---------------------------------------------------------------------------
`default_nettype none

module sysex_dump_check_unpack_top #(
  parameter int MAX_DECODED = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // byte input
  input  wire                  in_push,
  input  sdcu_pkg::sdcu_in_t   in_data,
  output logic                 in_full,
  // result output
  output logic                 out_empty,
  output sdcu_pkg::sdcu_out_t  out_data,
  input  wire                  out_pop,
  // configuration
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [3:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import sdcu_pkg::*;

  sdcu_cfg_t  cfg_r;
  sdcu_qent_t entry, head;
  logic       q_full, head_valid, head_pop, out_valid, accept, cfg_wr;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.product_id    <= RESET_PRODUCT;
      cfg_r.command_code  <= RESET_COMMAND;
      cfg_r.unpack_enable <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_PRODUCT_ID:    cfg_r.product_id    <= pwdata[6:0];
        REG_COMMAND_CODE:  cfg_r.command_code  <= pwdata[6:0];
        REG_UNPACK_ENABLE: cfg_r.unpack_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[3:2])
      REG_PRODUCT_ID:    prdata = {25'b0, cfg_r.product_id};
      REG_COMMAND_CODE:  prdata = {25'b0, cfg_r.command_code};
      REG_UNPACK_ENABLE: prdata = {31'b0, cfg_r.unpack_enable};
      default:           prdata = '0;
    endcase
  end

  // input request handshake
  assign accept    = in_push && !q_full;
  assign in_full   = q_full;
  assign out_empty = !out_valid;

  sdcu_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cfg     (cfg_r),
    .entry   (entry)
  );

  sdcu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (entry),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  sdcu_back #(
    .MAX_DECODED (MAX_DECODED)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .out_valid  (out_valid),
    .out_item   (out_data),
    .out_pop    (out_pop)
  );

endmodule

`default_nettype wire

// ----- sv/sdcu_front.sv -----
// ---------------------------------------------------------------------------
// sdcu_front
// tracks the byte position and classifies each accepted byte for the back end
// ---------------------------------------------------------------------------
`default_nettype none

module sdcu_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  accept,
  input  sdcu_pkg::sdcu_in_t   in_data,
  input  sdcu_pkg::sdcu_cfg_t  cfg,
  output sdcu_pkg::sdcu_qent_t entry
);
  import sdcu_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  expect_byte;

  // expected header byte by position
  always_comb begin
    case (pos_r[2:0])
      3'd0:    expect_byte = SOX_BYTE;
      3'd2:    expect_byte = MAN_ID1;
      3'd3:    expect_byte = MAN_ID2;
      3'd4:    expect_byte = {1'b0, cfg.product_id};
      3'd6:    expect_byte = {1'b0, cfg.command_code};
      default: expect_byte = 8'h00;
    endcase
  end

  // classification flags
  always_comb begin
    entry.data    = in_data.data_byte;
    entry.eom     = in_data.end_of_message;
    entry.hdr_err = (pos_r < 16'd7) && (in_data.data_byte != expect_byte);
    entry.pos_ge1 = (pos_r >= 16'd1);
    entry.pos_is9 = (pos_r == 16'd9);
    entry.sum_en  = (pos_r >= 16'd13);
    entry.dec_en  = (pos_r >= 16'd14);
    entry.n_ge13  = (pos_r >= 16'd12);
    entry.n_lt10  = (pos_r < 16'd9);
    entry.nm10    = pos_r - 16'd9;
  end

  // saturating position, cleared at the end of each message
  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_data.end_of_message) begin
        pos_nxt = '0;
      end else if (pos_r != 16'hffff) begin
        pos_nxt = pos_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sdcu_queue.sv -----
// ---------------------------------------------------------------------------
// sdcu_queue
// short first-in first-out queue between the front and back ends
// ---------------------------------------------------------------------------
`default_nettype none

module sdcu_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  sdcu_pkg::sdcu_qent_t push_data,
  output logic                 full,
  input  wire                  pop,
  output logic                 head_valid,
  output sdcu_pkg::sdcu_qent_t head
);
  import sdcu_pkg::*;

  sdcu_qent_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [Q_PTR_W:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == (Q_PTR_W+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // pointer and count update
  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- sv/sdcu_back.sv -----
// ---------------------------------------------------------------------------
// sdcu_back
// delay line, checksum, error tracking, 7-bit unpack and run-length decode
// ---------------------------------------------------------------------------
`default_nettype none

module sdcu_back #(
  parameter int MAX_DECODED = 4096
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  sdcu_pkg::sdcu_cfg_t  cfg,
  input  wire                  head_valid,
  input  sdcu_pkg::sdcu_qent_t head,
  output logic                 head_pop,
  output logic                 out_valid,
  output sdcu_pkg::sdcu_out_t  out_item,
  input  wire                  out_pop
);
  import sdcu_pkg::*;

  `include "sysex_dump_check_unpack_top_macros.svh"

  localparam logic [16:0] MaxDec = 17'(MAX_DECODED);

  logic [7:0]  td_r [4];
  logic [7:0]  td_nxt [4];
  logic [13:0] sum_r, sum_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [2:0]  gbi_r, gbi_nxt;
  logic [6:0]  hb_r, hb_nxt;
  logic [6:0]  pr_r, pr_nxt;
  logic [15:0] oc_r, oc_nxt;
  logic [6:0]  slot_r, slot_nxt;
  logic        out_v_r, out_v_nxt;
  sdcu_out_t   out_r;

  logic        emit, fire, out_free;
  sdcu_out_t   item;
  logic [6:0]  x;
  logic [7:0]  v;
  logic [14:0] sum_field, len_field;
  logic [16:0] run_total, lit_total;
  logic [2:0]  code;

  assign x         = td_r[0][6:0];
  assign v         = {hb_r[3'd7 - gbi_r], x};
  assign sum_field = {td_r[0], 7'b0} | {7'b0, td_r[1]};
  assign len_field = {td_r[2], 7'b0} | {7'b0, td_r[3]};
  assign run_total = {1'b0, oc_r} + {10'b0, pr_r};
  assign lit_total = {1'b0, oc_r} + 17'd1;

  // per-byte update of the message state
  always_comb begin
    td_nxt   = td_r;
    sum_nxt  = sum_r;
    err_nxt  = err_r;
    gbi_nxt  = gbi_r;
    hb_nxt   = hb_r;
    pr_nxt   = pr_r;
    oc_nxt   = oc_r;
    slot_nxt = slot_r;
    emit     = 1'b0;
    item     = '0;
    code     = err_r;
    if (head.eom) begin
      // trailer: final checks and status request
      if (!head.n_ge13 || head.data != EOX_BYTE) begin
        code = merge_err(code, ST_HEADER);
      end
      if (sum_field != {1'b0, sum_r}) begin
        code = merge_err(code, ST_CHECKSUM);
      end
      if (head.n_lt10 || {1'b0, len_field} != head.nm10) begin
        code = merge_err(code, ST_LENGTH);
      end
      if (pr_r != '0) begin
        code = merge_err(code, ST_BAD_RUN);
      end
      emit               = 1'b1;
      item.is_status     = 1'b1;
      item.status_code   = code;
      item.slot_byte     = slot_r;
      item.decoded_total = oc_r;
      td_nxt   = '{default: '0};
      sum_nxt  = '0;
      err_nxt  = '0;
      gbi_nxt  = '0;
      hb_nxt   = '0;
      pr_nxt   = '0;
      oc_nxt   = '0;
      slot_nxt = '0;
    end else begin
      // header and 7-bit checks
      if (head.hdr_err) begin
        err_nxt = merge_err(err_nxt, ST_HEADER);
      end
      if (head.pos_ge1 && head.data[7]) begin
        err_nxt = merge_err(err_nxt, ST_HIGH_BIT);
      end
      if (head.pos_is9) begin
        slot_nxt = head.data[6:0];
      end
      // checksum over the byte leaving the delay line
      if (head.sum_en) begin
        sum_nxt = sum_r + {6'b0, td_r[0]};
      end
      // unpack and run-length decode
      if (head.dec_en && cfg.unpack_enable && err_nxt == ST_OK) begin
        if (gbi_r == '0) begin
          hb_nxt  = x;
          gbi_nxt = 3'd1;
        end else begin
          gbi_nxt = (gbi_r == 3'd7) ? 3'd0 : gbi_r + 3'd1;
          if (pr_r != '0) begin
            pr_nxt = '0;
            if (run_total > MaxDec) begin
              err_nxt = merge_err(err_nxt, ST_OVERFLOW);
            end else begin
              oc_nxt = run_total[16] ? 16'hffff : run_total[15:0];
              emit   = 1'b1;
              item.out_value    = v;
              item.repeat_count = pr_r;
            end
          end else if (v[7]) begin
            if (v[6:0] == '0) begin
              err_nxt = merge_err(err_nxt, ST_BAD_RUN);
            end else begin
              pr_nxt = v[6:0];
            end
          end else begin
            oc_nxt = lit_total[16] ? 16'hffff : lit_total[15:0];
            emit   = 1'b1;
            item.out_value    = v;
            item.repeat_count = 7'd1;
          end
        end
      end
      item.slot_byte     = slot_nxt;
      item.decoded_total = oc_nxt;
      // delay line shift
      td_nxt[0] = td_r[1];
      td_nxt[1] = td_r[2];
      td_nxt[2] = td_r[3];
      td_nxt[3] = head.data;
    end
  end

  // advance when the result slot can take what this byte produces
  assign out_free  = !out_v_r || out_pop;
  assign fire      = head_valid && (!emit || out_free);
  assign head_pop  = fire;
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_comb begin
    out_v_nxt = out_v_r;
    if (fire && emit) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  // message state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_r    <= '{default: '0};
      sum_r   <= '0;
      err_r   <= '0;
      gbi_r   <= '0;
      hb_r    <= '0;
      pr_r    <= '0;
      oc_r    <= '0;
      slot_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (fire) begin
        td_r   <= td_nxt;
        sum_r  <= sum_nxt;
        err_r  <= err_nxt;
        gbi_r  <= gbi_nxt;
        hb_r   <= hb_nxt;
        pr_r   <= pr_nxt;
        oc_r   <= oc_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= item;
    end
  end

  // checks
  `SDCU_ASSERT_NEXT(a_result_holds, out_v_r && !out_pop, out_v_r && $stable(out_r), "result changed while waiting")
  `SDCU_ASSERT_SAME(a_decoded_fields, out_v_r && !out_r.is_status, out_r.repeat_count != '0 && out_r.status_code == ST_OK, "decoded request with bad count or code")
  `SDCU_ASSERT_NEXT(a_clear_after_status, fire && head.eom, gbi_r == '0 && pr_r == '0 && oc_r == '0 && err_r == ST_OK, "message state not cleared after trailer")

endmodule

`default_nettype wire
